// File: rtl/w3blur_pkg.sv
// shared types and constants of the weighted 3x3 blur block
package w3blur_pkg;

  localparam int PIX_W   = 16;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // one result item
  typedef struct packed {
    pix_t   pixel;
    coord_t row;
    coord_t col;
    logic   last;
    logic   fend;
  } res_t;

  // the result set of one input item, in emission order
  typedef struct packed {
    logic [2:0]     present;
    res_t [2:0]     res;
  } load_t;

endpackage

// File: rtl/w3blur_ifs.sv
// valid/ready stream interfaces for pixels in and results out
interface w3blur_in_if;
  logic              valid;
  logic              ready;
  w3blur_pkg::pix_t  pixel_in;

  modport source(output valid, output pixel_in, input ready);
  modport sink(input valid, input pixel_in, output ready);
endinterface

interface w3blur_out_if;
  logic                valid;
  logic                ready;
  w3blur_pkg::pix_t    pixel_out;
  w3blur_pkg::coord_t  out_row;
  w3blur_pkg::coord_t  out_col;
  logic                last_of_run;
  logic                frame_end;

  modport source(output valid, output pixel_out, output out_row, output out_col,
                 output last_of_run, output frame_end, input ready);
  modport sink(input valid, input pixel_out, input out_row, input out_col,
               input last_of_run, input frame_end, output ready);
endinterface

// File: rtl/weighted_3x3_blur.sv
// weighted 3x3 blur top level: line store memory, window, sum and divide pipeline
// path: a pixel moves through stages a, b, c and d, and its results through the result buffer
// throughput: one pixel per cycle while each pixel yields at most one result and the
//   output port is ready; a pixel with two or three results (last column, last row)
//   holds the single result port for each of them, which backs up into the pixel input
// reset: row and column counters clear, width and height return to 64, the window
//   clears; the line store memory is not cleared and holds no valid state after reset
module weighted_3x3_blur #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  w3blur_in_if.sink              in_stream,
  w3blur_out_if.source           out_stream,
  input  logic                   cfg_we,
  input  w3blur_pkg::cfg_idx_t   cfg_index,
  input  w3blur_pkg::cfg_data_t  cfg_wdata
);
  import w3blur_pkg::*;

  localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam cfg_data_t WCAP = cfg_data_t'(WIDTH_CAP);
  localparam cfg_data_t HCAP = cfg_data_t'(1024);
  localparam coord_t DIM_RESET_M1 = coord_t'(63);

  // sum of weights is 14: divide by 2 with a shift, then by 7 with a reciprocal
  localparam int SUM_W   = 20;
  localparam int RECIP_W = 20;
  localparam int Q_SHIFT = 22;
  localparam int PROD_W  = SUM_W - 1 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP7 = RECIP_W'(599187);

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef pix_t [2:0]        col_t;

  typedef struct packed {
    pix_t   pixel;
    coord_t row;
    coord_t col;
    logic   e_diag;
    logic   blur;
    logic   e_up;
    logic   e_self;
    logic   fend;
  } meta_t;

  typedef struct packed {
    meta_t meta;
    pix_t  mid;
    pix_t  ctr;
  } pipe_t;

  // width or height minus one after the zero and cap rules
  function automatic coord_t dim_m1(cfg_data_t v, cfg_data_t cap);
    cfg_data_t e;
    if (v == '0) begin
      e = cfg_data_t'(1);
    end else if (v > cap) begin
      e = cap;
    end else begin
      e = v;
    end
    return coord_t'(e - cfg_data_t'(1));
  endfunction

  coord_t wm1_r, hm1_r;
  coord_t row_r, col_r, row_nxt, col_nxt;

  logic   in_fire, a_fire;
  logic   en_a, en_b, en_c, en_d;
  logic   va_r, vb_r, vc_r, vd_r;
  meta_t  meta_new;
  meta_t  a_r;
  pipe_t  b_r, c_r, d_r;
  sum_t   b_cl_r, b_cm_r, b_cr_r;
  sum_t   cl, cm, cr;
  sum_t   c_sum_r;
  logic [PROD_W-1:0] d_prod_r;
  pix_t   quot;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               fwd_r;
  addr_t              rd_addr, a_addr;
  pix_t               a_up, a_mid;

  col_t  wcol_a_r, wcol_b_r, new_col;

  logic  ld_ready;
  load_t ld_data;

  // pipeline advance, each stage moves when the next one is free or moving
  assign en_d = !vd_r || ld_ready;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_stream.ready = en_a;
  assign in_fire = in_stream.valid && en_a;
  assign a_fire  = va_r && en_b;

  // position counters
  always_comb begin
    if (col_r >= wm1_r) begin
      col_nxt = '0;
      row_nxt = (row_r >= hm1_r) ? '0 : row_r + coord_t'(1);
    end else begin
      col_nxt = col_r + coord_t'(1);
      row_nxt = row_r;
    end
  end

  // configuration writes restart the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= DIM_RESET_M1;
      hm1_r <= DIM_RESET_M1;
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  wm1_r <= dim_m1(cfg_wdata, WCAP);
        REG_FRAME_HEIGHT: hm1_r <= dim_m1(cfg_wdata, HCAP);
      endcase
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // which results this pixel causes
  always_comb begin
    meta_new.pixel  = in_stream.pixel_in;
    meta_new.row    = row_r;
    meta_new.col    = col_r;
    meta_new.e_diag = (row_r != '0) && (col_r != '0);
    meta_new.blur   = (row_r[COORD_W-1:1] != '0) && (col_r[COORD_W-1:1] != '0);
    meta_new.e_up   = (row_r != '0) && (col_r == wm1_r);
    meta_new.e_self = (row_r == hm1_r);
    meta_new.fend   = (col_r == wm1_r);
  end

  // line store: {older, newer} per column, read on transfer, written back in stage a
  assign rd_addr = addr_t'(col_r);
  assign a_addr  = addr_t'(a_r.col);

  always_ff @(posedge clk) begin
    if (a_fire) begin
      line_mem[a_addr] <= {a_mid, a_r.pixel};
    end
    if (in_fire) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  // forward the write-back of stage a when the next pixel reads the same column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r      <= a_fire && (a_addr == rd_addr);
      fwd_data_r <= {a_mid, a_r.pixel};
    end
  end

  assign a_up  = fwd_r ? fwd_data_r[2*PIX_W-1:PIX_W] : rd_data_r[2*PIX_W-1:PIX_W];
  assign a_mid = fwd_r ? fwd_data_r[PIX_W-1:0]       : rd_data_r[PIX_W-1:0];

  // new right column of the window and the weighted column sums
  always_comb begin
    new_col[0] = a_up;
    new_col[1] = a_mid;
    new_col[2] = a_r.pixel;
    cl = sum_t'(wcol_a_r[0]) + (sum_t'(wcol_a_r[1]) << 1) + sum_t'(wcol_a_r[2]);
    cm = (sum_t'(wcol_b_r[0]) + sum_t'(wcol_b_r[1]) + sum_t'(wcol_b_r[2])) << 1;
    cr = sum_t'(new_col[0]) + (sum_t'(new_col[1]) << 1) + sum_t'(new_col[2]);
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_a_r <= '0;
      wcol_b_r <= '0;
    end else if (a_fire) begin
      wcol_a_r <= wcol_b_r;
      wcol_b_r <= new_col;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_fire;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  // stage payloads: column sums, full sum, reciprocal product
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r <= meta_new;
    end
    if (a_fire) begin
      b_r.meta <= a_r;
      b_r.mid  <= a_mid;
      b_r.ctr  <= wcol_b_r[1];
      b_cl_r   <= cl;
      b_cm_r   <= cm;
      b_cr_r   <= cr;
    end
    if (vb_r && en_c) begin
      c_r     <= b_r;
      c_sum_r <= b_cl_r + b_cm_r + b_cr_r;
    end
    if (vc_r && en_d) begin
      d_r      <= c_r;
      d_prod_r <= PROD_W'(c_sum_r[SUM_W-1:1]) * PROD_W'(RECIP7);
    end
  end

  assign quot = d_prod_r[Q_SHIFT+PIX_W-1:Q_SHIFT];

  // result set of the pixel in stage d
  always_comb begin
    ld_data.present = {d_r.meta.e_self, d_r.meta.e_up, d_r.meta.e_diag};

    ld_data.res[0].pixel = d_r.meta.blur ? quot : d_r.ctr;
    ld_data.res[0].row   = d_r.meta.row - coord_t'(1);
    ld_data.res[0].col   = d_r.meta.col - coord_t'(1);
    ld_data.res[0].last  = !d_r.meta.e_up && !d_r.meta.e_self;
    ld_data.res[0].fend  = 1'b0;

    ld_data.res[1].pixel = d_r.mid;
    ld_data.res[1].row   = d_r.meta.row - coord_t'(1);
    ld_data.res[1].col   = d_r.meta.col;
    ld_data.res[1].last  = !d_r.meta.e_self;
    ld_data.res[1].fend  = 1'b0;

    ld_data.res[2].pixel = d_r.meta.pixel;
    ld_data.res[2].row   = d_r.meta.row;
    ld_data.res[2].col   = d_r.meta.col;
    ld_data.res[2].last  = 1'b1;
    ld_data.res[2].fend  = d_r.meta.fend;
  end

  w3blur_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (vd_r),
    .ld_ready   (ld_ready),
    .ld_data    (ld_data),
    .out_stream (out_stream)
  );

  // counters stay inside the configured frame
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wm1_r)
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hm1_r)
    else $error("row counter beyond frame height");

  // the last column wraps to column zero
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_we && (col_r == wm1_r) |=> col_r == '0)
    else $error("column counter did not wrap");

endmodule

// File: rtl/w3blur_resq.sv
// result buffer: holds the up to three results of one pixel and sends them in order
module w3blur_resq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_valid,
  output logic                ld_ready,
  input  w3blur_pkg::load_t   ld_data,
  w3blur_out_if.source        out_stream
);
  import w3blur_pkg::*;

  res_t       slot_r [3];
  res_t       slot_nxt [3];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] ld_count;
  logic       ld_fire;
  logic       out_fire;

  // transfer conditions
  assign out_fire = out_stream.valid && out_stream.ready;
  assign ld_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_stream.ready);
  assign ld_fire  = ld_valid && ld_ready;

  assign ld_count = 2'(ld_data.present[0]) + 2'(ld_data.present[1])
                  + 2'(ld_data.present[2]);

  // compact the present results on load, shift down on each transfer
  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (ld_fire) begin
      if (ld_data.present[0]) begin
        slot_nxt[0] = ld_data.res[0];
      end else if (ld_data.present[1]) begin
        slot_nxt[0] = ld_data.res[1];
      end else begin
        slot_nxt[0] = ld_data.res[2];
      end
      if (ld_data.present[0] && ld_data.present[1]) begin
        slot_nxt[1] = ld_data.res[1];
      end else begin
        slot_nxt[1] = ld_data.res[2];
      end
      slot_nxt[2] = ld_data.res[2];
      cnt_nxt     = ld_count;
    end else if (out_fire) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head slot drives the port
  assign out_stream.valid       = (cnt_r != 2'd0);
  assign out_stream.pixel_out   = slot_r[0].pixel;
  assign out_stream.out_row     = slot_r[0].row;
  assign out_stream.out_col     = slot_r[0].col;
  assign out_stream.last_of_run = slot_r[0].last;
  assign out_stream.frame_end   = slot_r[0].fend;

  // a loaded result set shows up at the port next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ld_fire && (ld_data.present != 3'b000) |=> out_stream.valid)
    else $error("loaded results not presented");

  // a transfer without reload drops exactly one entry
  a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !ld_fire |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("result count off after transfer");

  // an empty buffer always takes the next result set
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stream.valid |-> ld_ready)
    else $error("empty buffer refused a load");

endmodule

// File: dv/tb_weighted_3x3_blur.sv
// self-checking testbench for the weighted 3x3 blur: random stalls, frame settings, result checks
`timescale 1ns / 100ps

module tb_weighted_3x3_blur;
  import w3blur_pkg::*;

  localparam int unsigned LINE_DEPTH    = 1024;
  localparam int unsigned DIM_CAP       = 1024;
  localparam int unsigned RESET_DIM     = 64;
  localparam int unsigned WEIGHT_SUM    = 14;
  localparam int unsigned IDLE_PERCENT  = 22;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned WIDE_PIXELS   = 96;
  localparam int unsigned RANDOM_PIXELS = 340;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // predicts the blurred stream and checks the results in order
  class blur_scoreboard;
    pix_t        older_row[LINE_DEPTH];
    pix_t        newer_row[LINE_DEPTH];
    pix_t        window[9];
    int unsigned row_pos;
    int unsigned col_pos;
    cfg_data_t   width_reg;
    cfg_data_t   height_reg;
    res_t        expected_pixels[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = cfg_data_t'(RESET_DIM);
      height_reg = cfg_data_t'(RESET_DIM);
      mismatches = 0;
      checked    = 0;
    endfunction

    // zero counts as one, anything past the cap saturates
    function int unsigned clamp_dim(cfg_data_t v);
      if (v == 0) return 1;
      if (v > DIM_CAP) return DIM_CAP;
      return 32'(v);
    endfunction

    // any register write restarts the frame
    function void write_reg(cfg_idx_t idx, cfg_data_t v);
      if (idx == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void note_pixel(pix_t p);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned wsum;
      pix_t        above;
      pix_t        middle;
      pix_t        blurred;
      res_t        item;
      res_t        run[$];
      w      = clamp_dim(width_reg);
      h      = clamp_dim(height_reg);
      r      = row_pos;
      c      = col_pos;
      above  = older_row[c];
      middle = newer_row[c];

      // slide the window one column and load the new column
      for (int i = 0; i < 3; i++) begin
        window[i*3]   = window[i*3+1];
        window[i*3+1] = window[i*3+2];
      end
      window[2] = above;
      window[5] = middle;
      window[8] = p;
      older_row[c] = middle;
      newer_row[c] = p;

      // pixel up and to the left: blurred if interior, else passed through
      if (r >= 1 && c >= 1) begin
        if (r >= 2 && c >= 2) begin
          wsum = window[0] + 2 * window[1] + window[2]
               + 2 * window[3] + 2 * window[4] + 2 * window[5]
               + window[6] + 2 * window[7] + window[8];
          blurred = pix_t'(wsum / WEIGHT_SUM);
        end else begin
          blurred = window[4];
        end
        item = '{pixel: blurred, row: coord_t'(r - 1), col: coord_t'(c - 1),
                 last: 1'b0, fend: 1'b0};
        run.push_back(item);
      end
      // right border pixel of the previous row
      if (r >= 1 && c == w - 1) begin
        item = '{pixel: middle, row: coord_t'(r - 1), col: coord_t'(c),
                 last: 1'b0, fend: 1'b0};
        run.push_back(item);
      end
      // bottom row pixels pass straight out
      if (r == h - 1) begin
        item = '{pixel: p, row: coord_t'(r), col: coord_t'(c),
                 last: 1'b0, fend: (c == w - 1)};
        run.push_back(item);
      end
      if (run.size() != 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_pixels.push_back(run[i]);

      // raster counters wrap at the end of the frame
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: row %0d col %0d pixel_out %0d", got.row, got.col,
               got.pixel);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.pixel !== want.pixel) begin
        $error("pixel_out at (%0d,%0d): expected %0d, actual %0d", want.row, want.col,
               want.pixel, got.pixel);
        mismatches++;
      end
      if (got.row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, got.col);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run at (%0d,%0d): expected %0b, actual %0b", want.row, want.col,
               want.last, got.last);
        mismatches++;
      end
      if (got.fend !== want.fend) begin
        $error("frame_end at (%0d,%0d): expected %0b, actual %0b", want.row, want.col,
               want.fend, got.fend);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  w3blur_in_if  pix_if();
  w3blur_out_if res_if();

  blur_scoreboard sb = new();

  bit          no_gaps = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned random_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  weighted_3x3_blur #(.MAX_WIDTH(LINE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (pix_if),
    .out_stream (res_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weighted_3x3_blur test failed");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready value
  always @(posedge clk) begin : result_monitor
    res_t seen;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen = '{pixel: res_if.pixel_out, row: res_if.out_row, col: res_if.out_col,
                 last: res_if.last_of_run, fend: res_if.frame_end};
        sb.check_result(seen);
      end
      res_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic pix_t random_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 7) return '0;
    if (pick < 14) return '1;
    return pix_t'($urandom);
  endfunction

  task automatic send_pixel(input pix_t value);
    int unsigned idle_cycles;
    idle_cycles = 0;
    if (!no_gaps) while ($urandom_range(99) < IDLE_PERCENT) idle_cycles++;
    if (idle_cycles != 0) begin
      pix_if.valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= value;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sb.note_pixel(value);
    pixels_sent++;
  endtask

  // stop sending until every predicted result has arrived
  task automatic hold_until_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
  endtask

  // registers change only once the pipeline is empty
  task automatic configure(input bit set_width, input bit set_height,
                           input cfg_data_t width_val, input cfg_data_t height_val);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (set_width) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_wdata <= width_val;
      @(posedge clk);
      sb.write_reg(REG_FRAME_WIDTH, width_val);
    end
    if (set_height) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_wdata <= height_val;
      @(posedge clk);
      sb.write_reg(REG_FRAME_HEIGHT, height_val);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_pixels(input int unsigned count, input bit pause_midway);
    for (int unsigned k = 0; k < count; k++) begin
      if ((pause_midway && k == count / 2) || $urandom_range(199) == 0) hold_until_drained();
      send_pixel(random_pixel());
    end
  endtask

  initial begin
    int unsigned sel;
    int unsigned frame_size;
    int unsigned count;
    bit          set_w;
    bit          set_h;
    bit          first_phase;
    cfg_data_t   next_w;
    cfg_data_t   next_h;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_FRAME_WIDTH;
    cfg_wdata       <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: first row is silent
    send_pixel('1);
    send_pixel('0);

    // partial frame, then a height write restarts it
    configure(1'b1, 1'b1, cfg_data_t'(3), cfg_data_t'(3));
    for (int k = 0; k < 4; k++) send_pixel(random_pixel());
    configure(1'b0, 1'b1, cfg_data_t'(0), cfg_data_t'(3));

    // checkerboard of extremes, then an all-max frame for the widest sum
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? pix_t'(0) : {PIX_W{1'b1}});
    for (int k = 0; k < 9; k++) send_pixel('1);

    // zero dimensions behave as a single pixel frame
    configure(1'b1, 1'b1, cfg_data_t'(0), cfg_data_t'(0));
    send_pixel('1);
    send_pixel('0);

    // width register saturating to the widest row, one row so every pixel is output
    configure(1'b1, 1'b1, '1, cfg_data_t'(1));
    no_gaps = 1'b1;
    run_random_pixels(WIDE_PIXELS, 1'b1);
    no_gaps = 1'b0;

    // tallest frame and exact maximum dimensions, only the first rows
    configure(1'b1, 1'b1, cfg_data_t'(1), '1);
    run_random_pixels(6, 1'b0);
    configure(1'b1, 1'b1, cfg_data_t'(2), cfg_data_t'(DIM_CAP));
    run_random_pixels(7, 1'b0);
    configure(1'b1, 1'b0, cfg_data_t'(DIM_CAP), cfg_data_t'(0));
    run_random_pixels(5, 1'b0);

    // random small frames, mostly whole frames back to back
    first_phase = 1'b1;
    while (random_sent < RANDOM_PIXELS) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        next_w = cfg_data_t'($urandom_range(1, 9));
        next_h = cfg_data_t'($urandom_range(1, 7));
      end else if (sel < 85) begin
        next_w = cfg_data_t'($urandom_range(0, 3));
        next_h = cfg_data_t'($urandom_range(0, 3));
      end else begin
        next_w = cfg_data_t'($urandom_range(10, 40));
        next_h = cfg_data_t'($urandom_range(3, 5));
      end
      sel   = $urandom_range(3);
      set_w = (sel != 1);
      set_h = (sel != 0);
      frame_size = sb.clamp_dim(set_w ? next_w : sb.width_reg)
                 * sb.clamp_dim(set_h ? next_h : sb.height_reg);
      if ($urandom_range(9) < 7) count = frame_size * $urandom_range(1, 2);
      else count = $urandom_range(1, 2 * frame_size);
      if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
      configure(set_w, set_h, next_w, next_h);
      run_random_pixels(count, first_phase || ($urandom_range(9) == 0));
      first_phase = 1'b0;
      random_sent += count;
    end

    hold_until_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d pixels under %0d register settings, %0d results compared",
             pixels_sent, settings_used, sb.checked);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("weighted_3x3_blur test passed");
    end else begin
      $display("weighted_3x3_blur test failed");
    end
    $finish;
  end

endmodule
